FILE: hdl/hwo_pkg.sv
// Shared types, constants and helper functions for the Hermite wavetable oscillator.
package hwo_pkg;

  // Table geometry
  localparam int MAX_TABLE_BITS = 10;
  localparam int TABLE_DEPTH    = (1 << MAX_TABLE_BITS) + 3;
  localparam int IDX_W          = $clog2(TABLE_DEPTH);
  localparam int L_W            = $clog2(MAX_TABLE_BITS + 1);
  localparam int WORD_W         = 16;
  localparam int SAMPLE_BITS    = 16;
  localparam int PHASE_W        = 32;
  localparam int MU_W           = 16;
  localparam int FREQ_W         = 24;
  localparam int OP_W           = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TENSION    = 2'd3;
  localparam logic [3:0]           TABLE_LOG2_RST = 4'd9;

  // Operation codes
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_PHASE  = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

  // Shared multiply-accumulate unit
  localparam int OPA_W   = 21;
  localparam int OPB_W   = 24;
  localparam int PROD_W  = OPA_W + OPB_W;
  localparam int ACC_W   = 58;
  localparam int VAL_W   = 38;
  localparam int SPLIT_W = 18;
  localparam int DIFF_W  = WORD_W + 1;
  localparam int K_W     = 18;

  // Fixed-point constants
  localparam logic signed [K_W-1:0]   K_ONE       = 18'sd16384;
  localparam logic signed [WORD_W-1:0] TENSION_MAX = 16'sd16384;
  localparam logic signed [WORD_W-1:0] TENSION_MIN = -16'sd16384;
  localparam logic signed [OPB_W-1:0] B_NEG_TWO   = -24'sd65536;
  localparam logic signed [OPB_W-1:0] B_THREE     = 24'sd98304;
  localparam logic signed [OPB_W-1:0] B_QUARTER   = 24'sd16384;
  localparam logic signed [ACC_W-1:0] ROUND_HALF  = ACC_W'(64'sd32768);
  localparam logic signed [ACC_W-1:0] SAT_HI      = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO      = -SAT_HI - ACC_W'(64'sd1);

  // Accumulator base selection
  typedef logic [1:0] base_sel_t;
  localparam base_sel_t BASE_ZERO   = 2'd0;
  localparam base_sel_t BASE_ACC    = 2'd1;
  localparam base_sel_t BASE_RND    = 2'd2;
  localparam base_sel_t BASE_ACC_SH = 2'd3;

  typedef struct packed {
    logic      en;
    base_sel_t base;
    logic      shift;
  } mac_ctrl_t;

  // Low part of a wide value, zero-extended as an operand
  function automatic logic signed [OPA_W-1:0] split_lo(input logic signed [VAL_W-1:0] v);
    return signed'({{(OPA_W - SPLIT_W){1'b0}}, v[SPLIT_W-1:0]});
  endfunction

  // High part of a wide value, arithmetic
  function automatic logic signed [OPA_W-1:0] split_hi(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] s;
    s = v >>> SPLIT_W;
    return s[OPA_W-1:0];
  endfunction

  // Saturate to the sample width
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > SAT_HI) r = SAT_HI;
    else if (v < SAT_LO) r = SAT_LO;
    else r = v;
    return r[SAMPLE_BITS-1:0];
  endfunction

endpackage

FILE: hdl/hermite_wavetable_oscillator.sv
// Top level: sequencer, configuration, phase and output register of the oscillator.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+--------------------------------------------
//  in       | in_valid / in_stall            | operation, table_index, table_value,
//           |                                | phase_value, frequency
//  out      | out_valid / out_stall          | sample
//  cfg      | cfg_we (no wait)               | cfg_index, cfg_wdata
//
// Table writes and phase sets are accepted every cycle while the sequencer is idle. A sample
// request holds in_stall high until the output register is free for its result: a disabled
// one goes straight to the hand-off, an enabled one first passes the single-port table reads,
// one setup step and 20 arithmetic steps (19 passes through the shared multiply-accumulate
// unit, then the phase update). Reset (rst_n low, synchronous) clears control, configuration and
// phase; the table is not cleared. A held result blocks the next sample only at hand-off.
module hermite_wavetable_oscillator (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input transactions
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [hwo_pkg::OP_W-1:0]               in_operation,
  input  logic [hwo_pkg::IDX_W-1:0]              in_table_index,
  input  logic signed [hwo_pkg::WORD_W-1:0]      in_table_value,
  input  logic [hwo_pkg::PHASE_W-1:0]            in_phase_value,
  input  logic signed [hwo_pkg::FREQ_W-1:0]      in_frequency,
  // Result transactions
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [hwo_pkg::SAMPLE_BITS-1:0] out_sample,
  // Configuration writes
  input  logic                                   cfg_we,
  input  logic [hwo_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [hwo_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import hwo_pkg::*;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_CALC = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  // Arithmetic steps
  localparam logic [4:0] STP_M0     = 5'd0;
  localparam logic [4:0] STP_M1     = 5'd1;
  localparam logic [4:0] STP_C3     = 5'd2;
  localparam logic [4:0] STP_C2A    = 5'd3;
  localparam logic [4:0] STP_C2B    = 5'd4;
  localparam logic [4:0] STP_C2C    = 5'd5;
  localparam logic [4:0] STP_H1L    = 5'd6;
  localparam logic [4:0] STP_H1H    = 5'd7;
  localparam logic [4:0] STP_H2CL   = 5'd8;
  localparam logic [4:0] STP_H2CH   = 5'd9;
  localparam logic [4:0] STP_H2TL   = 5'd10;
  localparam logic [4:0] STP_H2TH   = 5'd11;
  localparam logic [4:0] STP_H3CL   = 5'd12;
  localparam logic [4:0] STP_H3CH   = 5'd13;
  localparam logic [4:0] STP_H3TL   = 5'd14;
  localparam logic [4:0] STP_H3TH   = 5'd15;
  localparam logic [4:0] STP_BASE   = 5'd16;
  localparam logic [4:0] STP_FRQL   = 5'd17;
  localparam logic [4:0] STP_FRQH   = 5'd18;
  localparam logic [4:0] STP_LAST   = 5'd19;

  localparam logic [2:0] RD_LAST = 3'd4;

  logic [2:0]                     state_r, state_nxt;
  logic [2:0]                     rd_cnt_r;
  logic [4:0]                     step_r;

  logic                           enable_r;
  logic [3:0]                     table_log2_r;
  logic [PHASE_W-1:0]             step_per_hz_r;
  logic signed [WORD_W-1:0]       tension_r;
  logic [PHASE_W-1:0]             phase_r;

  logic                           out_valid_r;
  logic signed [SAMPLE_BITS-1:0]  out_sample_r;
  logic signed [SAMPLE_BITS-1:0]  samp_r;

  logic [IDX_W-1:0]               idx_r;
  logic [MU_W-1:0]                mu_r;
  logic signed [FREQ_W-1:0]       freq_r;
  logic signed [WORD_W-1:0]       pa_r, pb_r, pc_r, pd_r;
  logic signed [DIFF_W-1:0]       dca_r, ddb_r, dcb_r;
  logic signed [K_W-1:0]          k_r, nk_r, n2k_r;
  logic signed [VAL_W-1:0]        m0_r, c2_r, c3_r, t_r;

  logic                           in_acc;
  logic                           tbl_we;
  logic [IDX_W-1:0]               tbl_addr;
  logic signed [WORD_W-1:0]       tbl_rd;
  logic                           out_free;
  logic                           emit_load;

  logic [L_W-1:0]                 lsel;
  logic [PHASE_W-1:0]             ph_shr;
  logic [PHASE_W-1:0]             ph_shl;
  logic signed [WORD_W-1:0]       ten_cl;
  logic signed [K_W-1:0]          k_c;

  mac_ctrl_t                      mac_ctrl;
  logic signed [OPA_W-1:0]        op_a;
  logic signed [OPB_W-1:0]        op_b;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        acc_sh;
  logic signed [ACC_W-1:0]        y_full;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_load = (state_r == ST_EMIT) && out_free;

  // Table port: writes come straight from accepted transactions
  assign tbl_we   = in_acc && (in_operation == OP_WRITE) &&
                    (in_table_index < IDX_W'(TABLE_DEPTH));
  assign tbl_addr = tbl_we ? in_table_index : (idx_r + IDX_W'(rd_cnt_r[1:0]));

  hwo_table u_table (
    .clk     (clk),
    .we      (tbl_we),
    .addr    (tbl_addr),
    .wr_data (in_table_value),
    .rd_data (tbl_rd)
  );

  // Table size clamp, base index and fraction from the phase
  always_comb begin
    if (table_log2_r < 4'd2) lsel = L_W'(2);
    else if (int'(table_log2_r) > MAX_TABLE_BITS) lsel = L_W'(MAX_TABLE_BITS);
    else lsel = L_W'(table_log2_r);
  end
  assign ph_shr = phase_r >> (PHASE_W - int'(lsel));
  assign ph_shl = phase_r << lsel;

  // Tension clamp and tangent scale
  always_comb begin
    if (tension_r > TENSION_MAX) ten_cl = TENSION_MAX;
    else if (tension_r < TENSION_MIN) ten_cl = TENSION_MIN;
    else ten_cl = tension_r;
  end
  assign k_c = K_ONE - K_W'(ten_cl);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_operation == OP_SAMPLE)) begin
          state_nxt = enable_r ? ST_READ : ST_EMIT;
        end
      end
      ST_READ: begin
        if (rd_cnt_r == RD_LAST) state_nxt = ST_PREP;
      end
      ST_PREP: state_nxt = ST_CALC;
      ST_CALC: begin
        if (step_r == STP_LAST) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Drive the shared unit for each arithmetic step
  always_comb begin
    op_a     = '0;
    op_b     = '0;
    mac_ctrl = '{en: 1'b0, base: BASE_ZERO, shift: 1'b0};
    if (state_r == ST_CALC) begin
      mac_ctrl.en = 1'b1;
      unique case (step_r)
        STP_M0:   begin op_a = OPA_W'(dca_r); op_b = OPB_W'(k_r); end
        STP_M1:   begin op_a = OPA_W'(ddb_r); op_b = OPB_W'(k_r);
                        mac_ctrl.base = BASE_ACC; end
        STP_C3:   begin op_a = OPA_W'(dcb_r); op_b = B_NEG_TWO;
                        mac_ctrl.base = BASE_ACC; end
        STP_C2A:  begin op_a = OPA_W'(dcb_r); op_b = B_THREE; end
        STP_C2B:  begin op_a = OPA_W'(dca_r); op_b = OPB_W'(n2k_r);
                        mac_ctrl.base = BASE_ACC; end
        STP_C2C:  begin op_a = OPA_W'(ddb_r); op_b = OPB_W'(nk_r);
                        mac_ctrl.base = BASE_ACC; end
        STP_H1L:  begin op_a = split_lo(c3_r); op_b = OPB_W'({1'b0, mu_r});
                        mac_ctrl.base = BASE_RND; end
        STP_H1H:  begin op_a = split_hi(c3_r); op_b = OPB_W'({1'b0, mu_r});
                        mac_ctrl.base = BASE_ACC; mac_ctrl.shift = 1'b1; end
        STP_H2CL: begin op_a = split_lo(c2_r); op_b = OPB_W'({1'b0, mu_r});
                        mac_ctrl.base = BASE_RND; end
        STP_H2CH: begin op_a = split_hi(c2_r); op_b = OPB_W'({1'b0, mu_r});
                        mac_ctrl.base = BASE_ACC; mac_ctrl.shift = 1'b1; end
        STP_H2TL: begin op_a = split_lo(t_r); op_b = OPB_W'({1'b0, mu_r});
                        mac_ctrl.base = BASE_ACC; end
        STP_H2TH: begin op_a = split_hi(t_r); op_b = OPB_W'({1'b0, mu_r});
                        mac_ctrl.base = BASE_ACC; mac_ctrl.shift = 1'b1; end
        STP_H3CL: begin op_a = split_lo(m0_r); op_b = OPB_W'({1'b0, mu_r});
                        mac_ctrl.base = BASE_RND; end
        STP_H3CH: begin op_a = split_hi(m0_r); op_b = OPB_W'({1'b0, mu_r});
                        mac_ctrl.base = BASE_ACC; mac_ctrl.shift = 1'b1; end
        STP_H3TL: begin op_a = split_lo(t_r); op_b = OPB_W'({1'b0, mu_r});
                        mac_ctrl.base = BASE_ACC; end
        STP_H3TH: begin op_a = split_hi(t_r); op_b = OPB_W'({1'b0, mu_r});
                        mac_ctrl.base = BASE_ACC; mac_ctrl.shift = 1'b1; end
        // b*32768 plus the half for the final rounding, as (2b+1)*16384
        STP_BASE: begin op_a = OPA_W'(signed'({pb_r, 1'b1})); op_b = B_QUARTER;
                        mac_ctrl.base = BASE_ACC_SH; end
        STP_FRQL: begin op_a = signed'(OPA_W'(step_per_hz_r[SPLIT_W-1:0]));
                        op_b = freq_r; end
        STP_FRQH: begin op_a = signed'(OPA_W'(step_per_hz_r[PHASE_W-1:SPLIT_W]));
                        op_b = freq_r; mac_ctrl.base = BASE_ACC; mac_ctrl.shift = 1'b1; end
        default:  mac_ctrl.en = 1'b0;
      endcase
    end
  end

  hwo_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  assign acc_sh = acc >>> MU_W;
  assign y_full = acc >>> (MU_W - 1);

  // Control, configuration and phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      rd_cnt_r      <= '0;
      step_r        <= '0;
      enable_r      <= 1'b0;
      table_log2_r  <= TABLE_LOG2_RST;
      step_per_hz_r <= '0;
      tension_r     <= '0;
      phase_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Write configuration registers
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENABLE:     enable_r      <= cfg_wdata[0];
          CFG_TABLE_LOG2: table_log2_r  <= cfg_wdata[3:0];
          CFG_STEP:       step_per_hz_r <= cfg_wdata;
          CFG_TENSION:    tension_r     <= signed'(cfg_wdata[WORD_W-1:0]);
          default:        enable_r      <= enable_r;
        endcase
      end

      // Advance the read and step counters
      if (state_r == ST_READ) rd_cnt_r <= rd_cnt_r + 3'd1;
      else rd_cnt_r <= '0;
      if (state_r == ST_CALC) step_r <= step_r + 5'd1;
      else step_r <= '0;

      // Set or advance the phase
      if (in_acc && (in_operation == OP_PHASE)) begin
        phase_r <= in_phase_value;
      end else if (state_r == ST_CALC && step_r == STP_LAST) begin
        phase_r <= phase_r + acc[PHASE_W+7:8];
      end

      // Load the output register, drop it once taken
      if (emit_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc && (in_operation == OP_SAMPLE)) begin
      idx_r  <= ph_shr[IDX_W-1:0];
      mu_r   <= ph_shl[PHASE_W-1:PHASE_W-MU_W];
      freq_r <= in_frequency;
      samp_r <= '0;
    end

    // Shift in the four neighbor points
    if (state_r == ST_READ && rd_cnt_r != 3'd0) begin
      pa_r <= pb_r;
      pb_r <= pc_r;
      pc_r <= pd_r;
      pd_r <= tbl_rd;
    end

    if (state_r == ST_PREP) begin
      dca_r <= DIFF_W'(pc_r) - DIFF_W'(pa_r);
      ddb_r <= DIFF_W'(pd_r) - DIFF_W'(pb_r);
      dcb_r <= DIFF_W'(pc_r) - DIFF_W'(pb_r);
      k_r   <= k_c;
      nk_r  <= -k_c;
      n2k_r <= -(k_c <<< 1);
    end

    // Capture coefficients and Horner partial results
    if (state_r == ST_CALC) begin
      if (step_r == STP_M1)   m0_r   <= acc[VAL_W-1:0];
      if (step_r == STP_C2A)  c3_r   <= acc[VAL_W-1:0];
      if (step_r == STP_H1L)  c2_r   <= acc[VAL_W-1:0];
      if (step_r == STP_H2CL) t_r    <= acc_sh[VAL_W-1:0];
      if (step_r == STP_H3CL) t_r    <= acc_sh[VAL_W-1:0];
      if (step_r == STP_FRQL) samp_r <= sat_sample(y_full);
    end

    if (emit_load) out_sample_r <= samp_r;
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

`ifndef NO_ASSERTIONS
  a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (rd_cnt_r <= RD_LAST))
    else $error("table read counter overran");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> (step_r <= STP_LAST))
    else $error("arithmetic step counter overran");

  a_emit_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && $past(state_r) != ST_EMIT) |->
      ($past(state_r) == ST_CALC || $past(state_r) == ST_IDLE))
    else $error("result stage entered from a wrong state");

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_valid_r && out_stall) |=> (state_r == ST_EMIT))
    else $error("result left the sequencer while the output was still held");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |=> (state_r == ST_IDLE))
    else $error("table write started a computation");
`endif

endmodule

FILE: hdl/hwo_table.sv
// Single-port wavetable memory with registered read data.
module hwo_table (
  input  logic                              clk,
  input  logic                              we,
  input  logic [hwo_pkg::IDX_W-1:0]         addr,
  input  logic signed [hwo_pkg::WORD_W-1:0] wr_data,
  output logic signed [hwo_pkg::WORD_W-1:0] rd_data
);
  import hwo_pkg::*;

  logic signed [WORD_W-1:0] mem [TABLE_DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wr_data;
    end
    rd_data_r <= mem[addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/hwo_mac.sv
// Shared multiply-accumulate unit: one signed multiply and one wide add per cycle.
module hwo_mac (
  input  logic                             clk,
  input  hwo_pkg::mac_ctrl_t               ctrl,
  input  logic signed [hwo_pkg::OPA_W-1:0] op_a,
  input  logic signed [hwo_pkg::OPB_W-1:0] op_b,
  output logic signed [hwo_pkg::ACC_W-1:0] acc
);
  import hwo_pkg::*;

  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  base;

  // Multiply and align the partial product
  assign prod     = op_a * op_b;
  assign prod_ext = ctrl.shift ? (ACC_W'(prod) <<< SPLIT_W) : ACC_W'(prod);

  // Pick what the product adds to
  always_comb begin
    unique case (ctrl.base)
      BASE_ZERO:   base = '0;
      BASE_ACC:    base = acc_r;
      BASE_RND:    base = ROUND_HALF;
      BASE_ACC_SH: base = acc_r >>> MU_W;
      default:     base = '0;
    endcase
  end

  assign acc_nxt = base + prod_ext;

  // Accumulate when enabled
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Hermite wavetable oscillator: directed and random traffic.
module tb;
  import hwo_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int RANDOM_SEGMENTS = 4;
  localparam int SEGMENT_ITEMS   = 32;
  localparam int TAIL_ITEMS      = 32;
  localparam int RANDOM_LOG2_MAX = 8;
  localparam int LOADED_DEPTH    = (1 << RANDOM_LOG2_MAX) + 3;
  localparam longint SAMPLE_MAX  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN  = -SAMPLE_MAX - 1;
  localparam longint TENSION_ONE = 16384;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic [IDX_W-1:0]         index;
    logic signed [WORD_W-1:0] value;
    logic [PHASE_W-1:0]       phase_v;
    logic signed [FREQ_W-1:0] freq;
  } osc_req_t;

  logic                          clk;
  logic                          rst_n          = 1'b0;
  logic                          in_valid       = 1'b0;
  logic                          in_stall;
  logic [OP_W-1:0]               in_operation   = '0;
  logic [IDX_W-1:0]              in_table_index = '0;
  logic signed [WORD_W-1:0]      in_table_value = '0;
  logic [PHASE_W-1:0]            in_phase_value = '0;
  logic signed [FREQ_W-1:0]      in_frequency   = '0;
  logic                          out_valid;
  logic                          out_stall      = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index      = '0;
  logic [CFG_DATA_W-1:0]         cfg_wdata      = '0;

  // Behavioral copy of the oscillator state and registers
  logic signed [WORD_W-1:0]      wave_mem [TABLE_DEPTH];
  logic [PHASE_W-1:0]            osc_phase   = '0;
  logic                          reg_enable  = 1'b0;
  logic [3:0]                    reg_log2    = TABLE_LOG2_RST;
  logic [31:0]                   reg_step    = '0;
  logic signed [15:0]            reg_tension = '0;
  logic signed [SAMPLE_BITS-1:0] pending_samples [$];

  int          error_count = 0;
  int          idle_cycles = 0;
  bit          quiet_tail  = 1'b0;
  int unsigned gap_pct     = 20;
  int unsigned stall_pct   = 20;
  int unsigned stall_left  = 0;

  hermite_wavetable_oscillator u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .in_phase_value (in_phase_value),
    .in_frequency   (in_frequency),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample     (out_sample),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Throttle the result channel in random stall bursts
  always @(posedge clk) begin
    if (quiet_tail || !rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result transaction with the oldest expected sample
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected result transaction: sample %0d", out_sample);
        error_count++;
      end else begin
        if (out_sample !== pending_samples[0]) begin
          $error("sample mismatch: expected %0d, actual %0d", pending_samples[0], out_sample);
          error_count++;
        end
        void'(pending_samples.pop_front());
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("hermite_wavetable_oscillator regression: fail");
      $finish;
    end
  end

  // Shift right rounding half toward plus infinity
  function automatic longint round_shift_q(input longint v, input int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  // Interpolated sample at the current phase
  function automatic logic signed [SAMPLE_BITS-1:0] hermite_sample();
    int unsigned        span;
    logic [PHASE_W-1:0] point;
    logic [PHASE_W-1:0] shifted;
    longint             frac, a, b, c, d, ten, k, m0, m1, c2, c3, acc;
    span = reg_log2;
    if (span < 2) span = 2;
    if (span > MAX_TABLE_BITS) span = MAX_TABLE_BITS;
    point   = osc_phase >> (PHASE_W - span);
    shifted = osc_phase << span;
    frac    = shifted[31:16];
    a = wave_mem[point];
    b = wave_mem[point + 1];
    c = wave_mem[point + 2];
    d = wave_mem[point + 3];
    ten = reg_tension;
    if (ten < -TENSION_ONE) ten = -TENSION_ONE;
    if (ten > TENSION_ONE) ten = TENSION_ONE;
    k  = TENSION_ONE - ten;
    m0 = (c - a) * k;
    m1 = (d - b) * k;
    c2 = 3 * (c - b) * 32768 - 2 * m0 - m1;
    c3 = 2 * (b - c) * 32768 + m0 + m1;
    // Horner evaluation in Q15
    acc = round_shift_q(c3 * frac, 16);
    acc = round_shift_q((acc + c2) * frac, 16);
    acc = round_shift_q((acc + m0) * frac, 16);
    acc = round_shift_q(acc + b * 32768, 15);
    if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
    if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
    return acc[SAMPLE_BITS-1:0];
  endfunction

  // Apply one accepted transaction to the model and, for a sample request, queue its sample
  function automatic void step_oscillator(input osc_req_t r);
    longint step_l;
    longint prod;
    case (r.op)
      OP_WRITE: begin
        if (r.index < TABLE_DEPTH) wave_mem[r.index] = r.value;
      end
      OP_PHASE: begin
        osc_phase = r.phase_v;
      end
      OP_SAMPLE: begin
        if (!reg_enable) begin
          pending_samples.push_back('0);
        end else begin
          pending_samples.push_back(hermite_sample());
          step_l    = reg_step;
          prod      = r.freq * step_l;
          osc_phase = osc_phase + prod[39:8];
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void update_register(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ENABLE:     reg_enable  = data[0];
      CFG_TABLE_LOG2: reg_log2    = data[3:0];
      CFG_STEP:       reg_step    = data;
      CFG_TENSION:    reg_tension = data[15:0];
      default: begin
      end
    endcase
  endfunction

  function automatic osc_req_t build_request(input logic [OP_W-1:0] op,
                                             input logic [IDX_W-1:0] index,
                                             input logic signed [WORD_W-1:0] value,
                                             input logic [PHASE_W-1:0] phase_v,
                                             input logic signed [FREQ_W-1:0] freq);
    osc_req_t r;
    r.op      = op;
    r.index   = index;
    r.value   = value;
    r.phase_v = phase_v;
    r.freq    = freq;
    return r;
  endfunction

  function automatic osc_req_t random_request();
    osc_req_t    r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)      r.op = OP_SAMPLE;
    else if (pick < 65) r.op = OP_PHASE;
    else if (pick < 95) r.op = OP_WRITE;
    else                r.op = OP_UNUSED;
    r.index = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom)
                                          : IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
    case ($urandom_range(0, 7))
      0:       r.value = 16'sh8000;
      1:       r.value = 16'sh7FFF;
      default: r.value = WORD_W'($urandom);
    endcase
    r.phase_v = $urandom;
    // Mix audio-range frequencies with the full signed range
    if ($urandom_range(0, 1) == 0)
      r.freq = FREQ_W'($urandom);
    else
      r.freq = FREQ_W'($urandom_range(0, 20000 * 256));
    return r;
  endfunction

  // Drive one input transaction and hold it until accepted
  task automatic send_request(input osc_req_t r);
    int unsigned gap;
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= r.op;
    in_table_index <= r.index;
    in_table_value <= r.value;
    in_phase_value <= r.phase_v;
    in_frequency   <= r.freq;
    do @(posedge clk); while (in_stall);
    step_oscillator(r);
  endtask

  // Hold off the sender until every expected sample has arrived
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_samples.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    update_register(idx, data);
  endtask

  // Drain the block, then write all four registers back to back
  task automatic program_regs(input logic [31:0] en_w, input logic [31:0] l2_w,
                              input logic [31:0] step_w, input logic [31:0] ten_w);
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write(CFG_ENABLE, en_w);
    cfg_write(CFG_TABLE_LOG2, l2_w);
    cfg_write(CFG_STEP, step_w);
    cfg_write(CFG_TENSION, ten_w);
    cfg_we <= 1'b0;
  endtask

  // Random table sizes stay within the loaded part of the table
  task automatic program_random_settings();
    logic [31:0] en_w, l2_w, step_w, ten_w;
    en_w    = $urandom;
    en_w[0] = ($urandom_range(0, 7) != 0);
    l2_w    = $urandom;
    case ($urandom_range(0, 3))
      0:       l2_w[3:0] = 4'd2;
      1:       l2_w[3:0] = 4'(RANDOM_LOG2_MAX);
      default: l2_w[3:0] = 4'($urandom_range(0, RANDOM_LOG2_MAX));
    endcase
    case ($urandom_range(0, 3))
      0:       step_w = 32'h0;
      1:       step_w = 32'hFFFF_FFFF;
      2:       step_w = $urandom_range(1, 1 << 20);
      default: step_w = $urandom;
    endcase
    ten_w = $urandom;
    case ($urandom_range(0, 4))
      0:       ten_w[15:0] = 16'hC000;
      1:       ten_w[15:0] = 16'h4000;
      2:       ten_w[15:0] = 16'h0000;
      default: ;
    endcase
    program_regs(en_w, l2_w, step_w, ten_w);
  endtask

  // Write the low part of the table that random traffic can reach
  task automatic load_wavetable();
    osc_req_t r;
    for (int i = 0; i < LOADED_DEPTH; i++) begin
      r       = random_request();
      r.op    = OP_WRITE;
      r.index = i[IDX_W-1:0];
      send_request(r);
    end
  endtask

  // Disabled block outputs zero and keeps its phase
  task automatic test_disabled_output();
    program_regs(32'h0, 32'd9, 32'h0100_0000, 32'h0);
    send_request(build_request(OP_PHASE, '0, '0, 32'h4000_0000, '0));
    send_request(build_request(OP_SAMPLE, '0, '0, '0, 24'h7F_FFFF));
    send_request(build_request(OP_SAMPLE, '0, '0, '0, 24'hFF_FFFF));
    program_regs(32'h1, 32'd9, 32'h0100_0000, 32'h0);
    send_request(build_request(OP_SAMPLE, '0, '0, '0, 24'h00_0000));
    send_request(build_request(OP_SAMPLE, '0, '0, '0, 24'h00_0100));
  endtask

  // Full-scale step with minimum tension overshoots and saturates
  task automatic test_overshoot_saturation();
    program_regs(32'h1, 32'd2, 32'h0, 32'hFFFF_C000);
    send_request(build_request(OP_WRITE, 11'd0, 16'sh8000, '0, '0));
    send_request(build_request(OP_WRITE, 11'd1, 16'sh7FFF, '0, '0));
    send_request(build_request(OP_WRITE, 11'd2, 16'sh7FFF, '0, '0));
    send_request(build_request(OP_WRITE, 11'd3, 16'sh8000, '0, '0));
    send_request(build_request(OP_PHASE, '0, '0, 32'h2000_0000, '0));
    send_request(build_request(OP_SAMPLE, '0, '0, '0, '0));
    send_request(build_request(OP_PHASE, '0, '0, 32'h3FFF_FFFF, '0));
    send_request(build_request(OP_SAMPLE, '0, '0, '0, '0));
    send_request(build_request(OP_PHASE, '0, '0, 32'h0000_0000, '0));
    send_request(build_request(OP_SAMPLE, '0, '0, '0, '0));
  endtask

  // Out-of-range table size and tension, extreme steps, unused operation, ignored writes
  task automatic test_register_clamps();
    program_regs(32'hFFFF_FFFF, 32'h0000_000F, 32'hFFFF_FFFF, 32'h0000_7FFF);
    // Load the top four points read by the last index of the largest table
    send_request(build_request(OP_WRITE, 11'd1023, 16'sh7FFF, '0, '0));
    send_request(build_request(OP_WRITE, 11'd1024, 16'sh8000, '0, '0));
    send_request(build_request(OP_WRITE, 11'd1025, 16'sh7FFF, '0, '0));
    send_request(build_request(OP_WRITE, 11'd1026, 16'sh0123, '0, '0));
    send_request(build_request(OP_PHASE, '0, '0, 32'hFFFF_FFFF, '0));
    send_request(build_request(OP_SAMPLE, '0, '0, '0, 24'h80_0000));
    send_request(build_request(OP_SAMPLE, '0, '0, '0, 24'h7F_FFFF));
    program_regs(32'h0000_0001, 32'hFFFF_FFF0, 32'h0000_0001, 32'hFFFF_8000);
    send_request(build_request(OP_SAMPLE, '0, '0, '0, 24'h7F_FFFF));
    send_request(build_request(OP_UNUSED, 11'h7FF, 16'sh7FFF, 32'hFFFF_FFFF, 24'hFF_FFFF));
    send_request(build_request(OP_SAMPLE, '0, '0, '0, 24'h80_0000));
    send_request(build_request(OP_WRITE, 11'd1027, 16'sh1234, '0, '0));
    send_request(build_request(OP_WRITE, 11'h7FF, 16'sh8000, '0, '0));
    send_request(build_request(OP_SAMPLE, '0, '0, '0, '0));
  endtask

  // Random segments, each under its own settings and throttling
  task automatic test_random_traffic();
    int pause_at;
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      pause_at  = $urandom_range(10, SEGMENT_ITEMS - 10);
      gap_pct   = (seg % 3 == 0) ? 0 : $urandom_range(10, 50);
      stall_pct = (seg % 3 == 1) ? 0 : $urandom_range(10, 50);
      program_random_settings();
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        if (n == pause_at) wait_results();
        send_request(random_request());
      end
    end
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_unthrottled_tail();
    quiet_tail = 1'b1;
    gap_pct    = 0;
    stall_pct  = 0;
    program_random_settings();
    for (int n = 0; n < TAIL_ITEMS; n++) send_request(random_request());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    load_wavetable();
    test_disabled_output();
    test_overshoot_saturation();
    test_register_clamps();
    test_random_traffic();
    test_unthrottled_tail();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_samples.size() == 0)
      $display("hermite_wavetable_oscillator regression: pass");
    else
      $display("hermite_wavetable_oscillator regression: fail");
    $finish;
  end

endmodule
